// File: src/cs_pkg.sv
// ----------------------------------------------------------------------------
// cs_pkg
// shared constants, controller states and command/status types for the
// cosine similarity core
// ----------------------------------------------------------------------------
package cs_pkg;

    localparam int ELEMENT_BITS = 16;
    localparam int MAX_LENGTH   = 4096;
    localparam int DOT_W        = 44;
    localparam int POW_W        = 43;
    localparam int CNT_W        = $clog2(MAX_LENGTH + 1);
    localparam int MAG_W        = DOT_W;
    localparam int PROD_W       = 2 * MAG_W;
    localparam int SIM_W        = 16;
    localparam int Q_W          = SIM_W - 1;
    localparam int X_W          = 2 * Q_W;
    localparam int QIDX_W       = $clog2(Q_W);
    localparam int MUL_STEPS    = MAG_W;
    localparam int DIV_STEPS    = X_W;
    localparam int SQRT_STEPS   = Q_W;
    localparam int STEP_W       = 6;

    typedef enum logic [3:0] {
        S_ACCUM,
        S_LOAD_P,
        S_MUL_P,
        S_LOAD_R,
        S_MUL_R,
        S_DIV_INIT,
        S_DIV,
        S_SQRT_INIT,
        S_SQRT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              accum;
        logic              load_p;
        logic              mul_step;
        logic              load_r;
        logic              div_init;
        logic              div_step;
        logic              sqrt_init;
        logic              sqrt_step;
        logic              load_out;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// File: src/cs_ctrl.sv
// ----------------------------------------------------------------------------
// cs_ctrl
// sequencer: accumulation, two shift-add products, long division and
// integer square root, then hand-off to the output register
// ----------------------------------------------------------------------------
module cs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_last_elem,
    output logic             s_ready,
    input  cs_pkg::status_t  status,
    output cs_pkg::cmd_t     cmd
);
    import cs_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_ACCUM;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_ACCUM: begin
                s_ready   = 1'b1;
                cmd.accum = s_valid;
                if (s_valid && s_last_elem) begin
                    state_next = S_LOAD_P;
                end
            end
            S_LOAD_P: begin
                cmd.load_p = 1'b1;
                cnt_next   = '0;
                state_next = S_MUL_P;
            end
            S_MUL_P: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(MUL_STEPS - 1)) begin
                    state_next = S_LOAD_R;
                end
            end
            S_LOAD_R: begin
                cmd.load_r = 1'b1;
                cnt_next   = '0;
                state_next = S_MUL_R;
            end
            S_MUL_R: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(MUL_STEPS - 1)) begin
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = S_SQRT_INIT;
                end
            end
            S_SQRT_INIT: begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SQRT;
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cmd.step      = STEP_W'(SQRT_STEPS - 1) - cnt_reg;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_ACCUM;
                end
            end
            default: begin
                state_next = S_ACCUM;
            end
        endcase
    end

endmodule

// File: src/cs_datapath.sv
// ----------------------------------------------------------------------------
// cs_datapath
// running sums, shared shift-add multiplier, restoring divider,
// bit-serial square root and result register
// ----------------------------------------------------------------------------
module cs_datapath (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  cs_pkg::cmd_t                            cmd,
    output cs_pkg::status_t                         status,
    input  logic signed [cs_pkg::ELEMENT_BITS-1:0]  s_first_elem,
    input  logic signed [cs_pkg::ELEMENT_BITS-1:0]  s_second_elem,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [cs_pkg::SIM_W-1:0]         m_similarity,
    output logic                                    m_zero_vector,
    output logic                                    m_sum_overflow
);
    import cs_pkg::*;

    localparam int PW = 2 * ELEMENT_BITS;

    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [POW_W-1:0]        pow1_reg, pow1_next, pow2_reg, pow2_next;
    logic                    sat_reg, sat_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic signed [PW-1:0]    prod_ab, sq_a, sq_b;
    logic signed [DOT_W:0]   dot_wide;
    logic [POW_W:0]          pow1_wide, pow2_wide;
    logic                    hit;

    logic [PROD_W-1:0]       mcand_reg, acc_reg, p_reg, rem_reg;
    logic [MAG_W-1:0]        mplier_reg, dot_mag;
    logic [PROD_W:0]         rem_dbl;
    logic                    ge_reg;
    logic [X_W-1:0]          x_reg;
    logic [Q_W-1:0]          q_reg, trial;
    logic [X_W-1:0]          trial_sq;

    logic                    valid_reg;
    logic signed [SIM_W-1:0] sim_reg, sim_next;
    logic                    zero_reg, zero_next, ovf_reg;

    assign prod_ab = s_first_elem * s_second_elem;
    assign sq_a    = s_first_elem * s_first_elem;
    assign sq_b    = s_second_elem * s_second_elem;

    always_comb begin
        hit       = 1'b0;
        dot_wide  = {dot_reg[DOT_W-1], dot_reg} +
                    {{(DOT_W + 1 - PW){prod_ab[PW-1]}}, prod_ab};
        pow1_wide = {1'b0, pow1_reg} + (POW_W + 1)'($unsigned(sq_a));
        pow2_wide = {1'b0, pow2_reg} + (POW_W + 1)'($unsigned(sq_b));
        dot_next  = dot_wide[DOT_W-1:0];
        pow1_next = pow1_wide[POW_W-1:0];
        pow2_next = pow2_wide[POW_W-1:0];
        if (dot_wide[DOT_W] != dot_wide[DOT_W-1]) begin
            hit      = 1'b1;
            dot_next = dot_wide[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
                                       : {1'b0, {(DOT_W-1){1'b1}}};
        end
        if (pow1_wide[POW_W]) begin
            hit       = 1'b1;
            pow1_next = '1;
        end
        if (pow2_wide[POW_W]) begin
            hit       = 1'b1;
            pow2_next = '1;
        end
        sat_next = sat_reg | hit;
        cnt_next = cnt_reg + 1'b1;
        if (cnt_reg >= CNT_W'(MAX_LENGTH)) begin
            dot_next  = dot_reg;
            pow1_next = pow1_reg;
            pow2_next = pow2_reg;
            sat_next  = 1'b1;
            cnt_next  = cnt_reg;
        end
    end

    // running sums
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load_out) begin
            dot_reg  <= '0;
            pow1_reg <= '0;
            pow2_reg <= '0;
            sat_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else if (cmd.accum) begin
            dot_reg  <= dot_next;
            pow1_reg <= pow1_next;
            pow2_reg <= pow2_next;
            sat_reg  <= sat_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign dot_mag  = dot_reg[DOT_W-1] ? MAG_W'(-dot_reg) : MAG_W'(dot_reg);
    assign rem_dbl  = {rem_reg, 1'b0};
    assign trial    = q_reg | (Q_W'(1) << cmd.step[QIDX_W-1:0]);
    assign trial_sq = X_W'(trial) * X_W'(trial);

    // shared multiplier, divider and square root
    always_ff @(posedge aclk) begin
        if (cmd.load_p) begin
            mcand_reg  <= PROD_W'(pow1_reg);
            mplier_reg <= MAG_W'(pow2_reg);
            acc_reg    <= '0;
        end else if (cmd.load_r) begin
            p_reg      <= acc_reg;
            mcand_reg  <= PROD_W'(dot_mag);
            mplier_reg <= dot_mag;
            acc_reg    <= '0;
        end else if (cmd.mul_step) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[MAG_W-1:1]};
        end
        if (cmd.div_init) begin
            ge_reg  <= acc_reg >= p_reg;
            rem_reg <= acc_reg;
            x_reg   <= '0;
        end else if (cmd.div_step) begin
            if (rem_dbl >= {1'b0, p_reg}) begin
                rem_reg <= PROD_W'(rem_dbl - {1'b0, p_reg});
                x_reg   <= {x_reg[X_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_dbl[PROD_W-1:0];
                x_reg   <= {x_reg[X_W-2:0], 1'b0};
            end
        end
        if (cmd.sqrt_init) begin
            q_reg <= '0;
        end else if (cmd.sqrt_step && trial_sq <= x_reg) begin
            q_reg <= trial;
        end
    end

    always_comb begin
        zero_next = (pow1_reg == '0) || (pow2_reg == '0);
        if (zero_next) begin
            sim_next = '0;
        end else if (ge_reg) begin
            sim_next = dot_reg[DOT_W-1] ? {1'b1, {Q_W{1'b0}}} : {1'b0, {Q_W{1'b1}}};
        end else if (dot_reg[DOT_W-1]) begin
            sim_next = -$signed({1'b0, q_reg});
        end else begin
            sim_next = $signed({1'b0, q_reg});
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            sim_reg  <= sim_next;
            zero_reg <= zero_next;
            ovf_reg  <= sat_reg;
        end
    end

    assign status.out_free = !valid_reg || m_ready;
    assign m_valid         = valid_reg;
    assign m_similarity    = sim_reg;
    assign m_zero_vector   = zero_reg;
    assign m_sum_overflow  = ovf_reg;

endmodule

// File: src/cosine_similarity_core.sv
// ----------------------------------------------------------------------------
// cosine_similarity_core
// streaming cosine similarity of two signed Q1.15 vectors
// ----------------------------------------------------------------------------
// input channel s_*: one element pair per transfer, s_last_elem marks the
// final pair of a vector; pairs stream at one per cycle while s_ready is high
// output channel m_*: one result per vector, similarity in Q1.15 with +1.0
// saturated to 32767, zero_vector when either magnitude is zero, and
// sum_overflow when pairs past MAX_LENGTH were dropped or a sum clamped
// after the last pair the core does the final math: two shift-add
// products on the shared multiplier, a restoring division to a 30-bit
// quotient and a bit-serial 15-bit square root, each after a set-up state,
// then a load into the result register; s_ready is low during that time
// the result register holds until m_ready; if the previous result is still
// waiting the core stays busy until it is taken
// reset clears the sums, the pair count, the flag and m_valid
// ----------------------------------------------------------------------------
module cosine_similarity_core (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [cs_pkg::ELEMENT_BITS-1:0]  s_first_elem,
    input  logic signed [cs_pkg::ELEMENT_BITS-1:0]  s_second_elem,
    input  logic                                    s_last_elem,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [cs_pkg::SIM_W-1:0]         m_similarity,
    output logic                                    m_zero_vector,
    output logic                                    m_sum_overflow
);
    import cs_pkg::*;

    cmd_t    cmd;
    status_t status;

    cs_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_elem (s_last_elem),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    cs_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_first_elem   (s_first_elem),
        .s_second_elem  (s_second_elem),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_similarity   (m_similarity),
        .m_zero_vector  (m_zero_vector),
        .m_sum_overflow (m_sum_overflow)
    );

endmodule
